/* rtl/core/lfd_pkg.sv */
// Shared types and constants for the LFO flanger delay mix block.
package lfd_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_LFO_RATE     = 3'd0;
    localparam logic [2:0] REG_PHASE_OFFSET = 3'd1;
    localparam logic [2:0] REG_DEPTH_STEPS  = 3'd2;
    localparam logic [2:0] REG_WAVEFORM     = 3'd3;
    localparam logic [2:0] REG_SAMPLE_RATE  = 3'd4;

    // Waveform codes; any other code selects the sine
    localparam logic [2:0] WAVE_TRIANGLE = 3'd1;
    localparam logic [2:0] WAVE_SQUARE   = 3'd2;
    localparam logic [2:0] WAVE_RISING   = 3'd3;
    localparam logic [2:0] WAVE_FALLING  = 3'd4;

    // Fixed-point constants
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [16:0] LFO_ONE     = 17'd65536;

    // Divider width: numerator is a 7-bit value shifted up by 16
    localparam int unsigned DIV_NW = 23;
    localparam int unsigned DIV_DW = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_ROM,
        ST_DIVX,
        ST_INC,
        ST_DIVI,
        ST_MUL,
        ST_MEM,
        ST_DATA,
        ST_OUT
    } lfd_state_t;

endpackage

/* rtl/core/lfd_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module lfd_ram #(
    parameter int unsigned WIDTH = 12,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and read; read data holds while no read is issued
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/lfo_flanger_delay_mix.sv */
// Top level of the LFO flanger: oscillator, iterative divider and delay line.
//
// Each accepted sample is averaged with the sample a modulated number of steps back in a
// DELAY_DEPTH-entry delay line held in a one-port-write, one-port-read RAM. A bit-serial
// 23-step divider runs once for the triangle and saw value when the rate is nonzero and
// always once more for the sine phase increment, the sine adds one table read, and every
// item then passes through a multiply step, a RAM step, a data step and a result step.
// The input is ready again in the cycle after the result is loaded, so the block takes a
// new sample only once it is through with the last one; a result that waits in the output
// register stalls the next item only when that item is done too. Entries not yet written
// since reset read as zero, tracked by the write pointer and a wrap flag, so no clearing
// pass is needed.
module lfo_flanger_delay_mix #(
    parameter int unsigned DELAY_DEPTH      = 1024,
    parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [11:0] s_sample_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_sample_out,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    import lfd_pkg::*;

    localparam int unsigned AW  = $clog2(DELAY_DEPTH);
    localparam int unsigned KW  = $clog2(SINE_TABLE_DEPTH);
    localparam int unsigned MDW = $clog2((DELAY_DEPTH * 127) / 100 + 1);

    // Constant tables: phase offset, maximum delay and sine
    logic [15:0]    off_tab  [128];
    logic [MDW-1:0] md_tab   [128];
    logic [16:0]    sine_rom [SINE_TABLE_DEPTH];

    for (genvar i = 0; i < 128; i++) begin : g_tab
        localparam logic [63:0] OFF = (64'(i) * 64'd65536) / 64'd100;
        localparam logic [63:0] MD  = (64'(i) * 64'(DELAY_DEPTH)) / 64'd100;
        assign off_tab[i] = OFF[15:0];
        assign md_tab[i]  = MD[MDW-1:0];
    end

    for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_sine
        localparam logic [63:0] DD = 64'(SINE_TABLE_DEPTH);
        localparam logic [63:0] M  = 64'd4 * 64'(k);
        localparam logic [63:0] Q  = M / DD;
        localparam logic [63:0] R  = M - Q * DD;
        localparam logic [63:0] T  = Q[0] ? (DD - R) : R;
        localparam logic [63:0] A  = (HALF_PI_Q30 * T) / DD;
        localparam logic [63:0] A2 = (A * A) >> 30;
        localparam logic [63:0] H1 = Q30_ONE - A2 / 64'd110;
        localparam logic [63:0] H2 = Q30_ONE - ((A2 * H1) >> 30) / 64'd72;
        localparam logic [63:0] H3 = Q30_ONE - ((A2 * H2) >> 30) / 64'd42;
        localparam logic [63:0] H4 = Q30_ONE - ((A2 * H3) >> 30) / 64'd20;
        localparam logic [63:0] H5 = Q30_ONE - ((A2 * H4) >> 30) / 64'd6;
        localparam logic [63:0] S0 = (A * H5) >> 30;
        localparam logic [63:0] S  = (S0 > Q30_ONE) ? Q30_ONE : S0;
        localparam logic [63:0] V  = (Q < 64'd2) ? ((Q30_ONE + S + 64'd16384) >> 15)
                                                 : ((Q30_ONE - S + 64'd16384) >> 15);
        assign sine_rom[k] = V[16:0];
    end

    // Configuration registers
    logic [6:0]  lfo_rate_reg;
    logic [6:0]  phase_offset_reg;
    logic [6:0]  depth_steps_reg;
    logic [2:0]  waveform_reg;
    logic [15:0] sample_rate_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lfo_rate_reg     <= 7'd10;
            phase_offset_reg <= 7'd0;
            depth_steps_reg  <= 7'd50;
            waveform_reg     <= 3'd0;
            sample_rate_reg  <= 16'd8000;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_LFO_RATE:     lfo_rate_reg     <= cfg_data[6:0];
                REG_PHASE_OFFSET: phase_offset_reg <= cfg_data[6:0];
                REG_DEPTH_STEPS:  depth_steps_reg  <= cfg_data[6:0];
                REG_WAVEFORM:     waveform_reg     <= cfg_data[2:0];
                REG_SAMPLE_RATE:  sample_rate_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // State and datapath registers
    lfd_state_t state_reg, state_next;

    logic [11:0]       cur_reg;
    logic [7:0]        pc_reg;
    logic [7:0]        c_reg;
    logic [6:0]        cm_reg;
    logic [15:0]       acc_reg;
    logic [KW-1:0]     idx_reg;
    logic [16:0]       x_reg;
    logic [AW-1:0]     wp_reg;
    logic              filled_reg;
    logic [AW-1:0]     delay_reg;
    logic              use_cur_reg;
    logic              rd_valid_reg;
    logic [11:0]       out_reg;
    logic              m_valid_reg;

    logic [DIV_NW-1:0] dv_num_reg;
    logic [DIV_DW:0]   dv_rem_reg;
    logic [DIV_NW-1:0] dv_quo_reg;
    logic [DIV_DW-1:0] dv_den_reg;
    logic [4:0]        dv_cnt_reg;

    // Control outputs of the sequencer
    logic ram_we;
    logic ram_re;
    logic out_load;

    logic [7:0]  f2;
    logic        f_zero;
    logic        wave_div;
    logic        dv_last;
    logic [11:0] ram_rdata;

    assign f2       = {lfo_rate_reg, 1'b0};
    assign f_zero   = (lfo_rate_reg == 7'd0);
    assign wave_div = !f_zero && ((waveform_reg == WAVE_TRIANGLE) ||
                      (waveform_reg == WAVE_RISING) || (waveform_reg == WAVE_FALLING));
    assign dv_last  = (dv_cnt_reg == 5'(DIV_NW - 1));

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_PREP;
            ST_PREP: begin
                if (wave_div) begin
                    state_next = ST_DIVX;
                end else if ((waveform_reg >= WAVE_TRIANGLE) &&
                             (waveform_reg <= WAVE_FALLING)) begin
                    state_next = ST_INC;
                end else begin
                    state_next = ST_ROM;
                end
            end
            ST_ROM:  state_next = ST_INC;
            ST_DIVX: if (dv_last) state_next = ST_INC;
            ST_INC:  state_next = ST_DIVI;
            ST_DIVI: if (dv_last) state_next = ST_MUL;
            ST_MUL:  state_next = ST_MEM;
            ST_MEM:  state_next = ST_DATA;
            ST_DATA: state_next = ST_OUT;
            ST_OUT:  if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready  = 1'b0;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_MEM: begin
                ram_we = 1'b1;
                ram_re = 1'b1;
            end
            ST_OUT:  out_load = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    // Combinational helpers
    logic [7:0]         c_eff;
    logic [6:0]         tri_span;
    logic [15:0]        ph;
    logic [31:0]        idx_prod;
    logic [DIV_DW:0]    rem_sh;
    logic               qbit;
    logic [16+MDW:0]    dly_prod;
    logic [MDW:0]       dly_full;
    logic [AW:0]        rd_wide;
    logic [AW-1:0]      rd_addr;
    logic [7:0]         pc_inc;
    logic [11:0]        old;
    logic [12:0]        sum;

    assign c_eff    = (pc_reg >= f2) ? 8'd0 : pc_reg;
    assign tri_span = (c_reg >= {1'b0, lfo_rate_reg}) ? 7'(c_reg - {1'b0, lfo_rate_reg})
                                                      : 7'({1'b0, lfo_rate_reg} - c_reg);
    assign ph       = acc_reg + off_tab[phase_offset_reg];
    assign idx_prod = 32'(ph) * 32'(SINE_TABLE_DEPTH);
    assign rem_sh   = {dv_rem_reg[DIV_DW-1:0], dv_num_reg[DIV_NW-1]};
    assign qbit     = (rem_sh >= {1'b0, dv_den_reg});
    assign dly_prod = (17+MDW)'(x_reg) * (17+MDW)'(md_tab[depth_steps_reg]);
    assign dly_full = dly_prod[16+MDW:16];
    assign rd_wide  = (wp_reg >= delay_reg) ? (AW+1)'(wp_reg - delay_reg)
                    : (AW+1)'((AW+1)'(wp_reg) + (AW+1)'(DELAY_DEPTH) - (AW+1)'(delay_reg));
    assign rd_addr  = rd_wide[AW-1:0];
    assign pc_inc   = c_reg + 8'd1;
    assign old      = use_cur_reg ? cur_reg : (rd_valid_reg ? ram_rdata : 12'd0);
    assign sum      = {1'b0, cur_reg} + {1'b0, old};

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pc_reg      <= 8'd0;
            acc_reg     <= 16'd0;
            wp_reg      <= '0;
            filled_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            // Advance the oscillator once the increment is known
            if (state_reg == ST_MUL) begin
                pc_reg  <= (pc_inc >= f2) ? 8'd0 : pc_inc;
                acc_reg <= acc_reg + ((sample_rate_reg == 16'd0) ? 16'd0 : dv_quo_reg[15:0]);
            end
            // Advance the write pointer; mark the line full on wrap
            if (ram_we) begin
                if (wp_reg == AW'(DELAY_DEPTH - 1)) begin
                    wp_reg     <= '0;
                    filled_reg <= 1'b1;
                end else begin
                    wp_reg <= wp_reg + 1'b1;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        // Capture the item and the effective counter
        if (s_valid && s_ready) begin
            cur_reg <= s_sample_in;
            c_reg   <= c_eff;
            cm_reg  <= (c_eff >= {1'b0, lfo_rate_reg}) ? 7'(c_eff - {1'b0, lfo_rate_reg})
                                                       : c_eff[6:0];
        end

        // Pick the LFO path; load the divider for every shape, though only the triangle and saw use it
        if (state_reg == ST_PREP) begin
            idx_reg <= idx_prod[16 +: KW];
            if (!f_zero && (waveform_reg == WAVE_SQUARE)) begin
                x_reg <= (cm_reg < (lfo_rate_reg >> 1)) ? 17'd0 : LFO_ONE;
            end else begin
                x_reg <= 17'd0;
            end
            dv_rem_reg <= '0;
            dv_cnt_reg <= '0;
            dv_den_reg <= DIV_DW'(lfo_rate_reg);
            if (waveform_reg == WAVE_TRIANGLE) begin
                dv_num_reg <= {tri_span, 16'd0};
            end else if (waveform_reg == WAVE_RISING) begin
                dv_num_reg <= {cm_reg, 16'd0};
            end else begin
                dv_num_reg <= {7'(lfo_rate_reg - cm_reg), 16'd0};
            end
        end

        if (state_reg == ST_ROM) begin
            x_reg <= sine_rom[idx_reg];
        end

        // Take the LFO quotient and load the phase increment division
        if (state_reg == ST_INC) begin
            if (wave_div) begin
                x_reg <= dv_quo_reg[16:0];
            end
            dv_rem_reg <= '0;
            dv_cnt_reg <= '0;
            dv_den_reg <= sample_rate_reg;
            dv_num_reg <= {lfo_rate_reg, 16'd0};
        end

        // One restoring divide step a cycle
        if ((state_reg == ST_DIVX) || (state_reg == ST_DIVI)) begin
            dv_rem_reg <= qbit ? (rem_sh - {1'b0, dv_den_reg}) : rem_sh;
            dv_quo_reg <= {dv_quo_reg[DIV_NW-2:0], qbit};
            dv_num_reg <= {dv_num_reg[DIV_NW-2:0], 1'b0};
            dv_cnt_reg <= dv_cnt_reg + 5'd1;
        end

        // Scale the LFO to a delay and clamp it to the line
        if (state_reg == ST_MUL) begin
            delay_reg <= (dly_full > (MDW+1)'(DELAY_DEPTH - 1)) ? AW'(DELAY_DEPTH - 1)
                                                                : dly_full[AW-1:0];
        end

        // Note whether the read entry holds a written sample
        if (state_reg == ST_MEM) begin
            use_cur_reg  <= (delay_reg == '0);
            rd_valid_reg <= filled_reg || (rd_addr < wp_reg);
        end

        if (state_reg == ST_DATA) begin
            out_reg <= sum[12:1];
        end

        if (out_load) begin
            m_sample_out <= out_reg;
        end
    end

    assign m_valid = m_valid_reg;

    lfd_ram #(
        .WIDTH (12),
        .DEPTH (DELAY_DEPTH)
    ) u_delay_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (cur_reg),
        .re    (ram_re),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

endmodule
